// File: hw/rtl/okvt_pkg.sv
// shared constants, types and codes for the ordered key-value table
`timescale 1ns / 1ps

package okvt_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_W    = 32;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 4;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [CNT_W-1:0]   count_t;
  typedef logic [IDX_W-1:0]   idx_t;

  typedef enum logic [2:0] {
    OP_INSERT  = 3'd0,
    OP_UPDATE  = 3'd1,
    OP_UPSERT  = 3'd2,
    OP_ERASE   = 3'd3,
    OP_LOOKUP  = 3'd4,
    OP_READPOS = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ABSENT  = 3'd1,
    ST_PRESENT = 3'd2,
    ST_FULL    = 3'd3,
    ST_RANGE   = 3'd4
  } status_t;

  // per-cell move control
  typedef struct packed {
    logic push;   // take the left neighbor's pair
    logic pull;   // take the right neighbor's pair
    logic write;  // overwrite the value in place
  } cell_ctrl_t;

endpackage

// File: hw/rtl/okvt_cell.sv
// one table cell: holds a key-value pair and compares it with the command key
`timescale 1ns / 1ps

module okvt_cell (
  input  logic                clk,
  input  okvt_pkg::cell_ctrl_t ctrl,
  input  okvt_pkg::key_t      left_key,
  input  okvt_pkg::value_t    left_value,
  input  okvt_pkg::key_t      right_key,
  input  okvt_pkg::value_t    right_value,
  input  okvt_pkg::key_t      cmd_key,
  input  okvt_pkg::value_t    cmd_value,
  output okvt_pkg::key_t      key,
  output okvt_pkg::value_t    value,
  output logic                match
);

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      key   <= left_key;
      value <= left_value;
    end else if (ctrl.pull) begin
      key   <= right_key;
      value <= right_value;
    end else if (ctrl.write) begin
      value <= cmd_value;
    end
  end

  assign match = (key == cmd_key);

endmodule

// File: hw/rtl/ordered_key_value_table_top.sv
// top level of the ordered key-value table: command register, cell row, result register
`timescale 1ns / 1ps

// Ordered table of up to 16 unique key-value pairs, newest at position 0. A command is
// registered on acceptance and executed as soon as the result register is free, when all
// cells compare their key against it in parallel and shift, pull or rewrite their pair in
// one step; the result is then held in an output register. With the result taken every
// cycle, one command is accepted per cycle. The entry count is cleared by reset; the cell
// contents need no clearing pass, since only positions below the count are ever used.
module ordered_key_value_table_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  logic [2:0]  op,
  input  logic [31:0] key,
  input  logic [31:0] value,
  input  logic [3:0]  position,
  output logic        res_valid,
  input  logic        res_ready,
  output logic        ok,
  output logic [2:0]  status,
  output logic [31:0] found_key,
  output logic [31:0] found_value,
  output logic [4:0]  entry_count
);

  localparam int N = okvt_pkg::CAPACITY;

  logic                 busy;
  logic [2:0]           cmd_op;
  okvt_pkg::key_t       cmd_key;
  okvt_pkg::value_t     cmd_value;
  logic [3:0]           cmd_pos;
  okvt_pkg::count_t     count;
  okvt_pkg::count_t     count_next;

  logic cmd_fire, res_free, do_work;

  okvt_pkg::key_t       cell_key    [N];
  okvt_pkg::value_t     cell_value  [N];
  okvt_pkg::key_t       left_key    [N];
  okvt_pkg::value_t     left_value  [N];
  okvt_pkg::key_t       right_key   [N];
  okvt_pkg::value_t     right_value [N];
  okvt_pkg::cell_ctrl_t cell_ctrl   [N];
  logic [N-1:0]         match;
  logic [N-1:0]         hit;
  logic [N-1:0]         pos_sel;

  logic                 any_hit;
  okvt_pkg::idx_t       hit_idx;
  okvt_pkg::value_t     hit_value;
  okvt_pkg::key_t       rd_key;
  okvt_pkg::value_t     rd_value;
  logic                 in_range;
  logic                 full;

  logic                 do_push, do_erase, do_write;
  logic                 r_ok;
  okvt_pkg::status_t    r_status;
  okvt_pkg::key_t       r_key;
  okvt_pkg::value_t     r_value;

  assign res_free  = !res_valid || res_ready;
  assign cmd_ready = !busy || res_free;
  assign cmd_fire  = cmd_valid && cmd_ready;
  assign do_work   = busy && res_free;

  // command register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (cmd_fire) begin
      busy <= 1'b1;
    end else if (do_work) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      cmd_op    <= op;
      cmd_key   <= okvt_pkg::key_t'(key);
      cmd_value <= okvt_pkg::value_t'(value);
      cmd_pos   <= position;
    end
  end

  // cell row
  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_key[i]   = cmd_key;
      assign left_value[i] = cmd_value;
    end else begin : g_inner
      assign left_key[i]   = cell_key[i-1];
      assign left_value[i] = cell_value[i-1];
    end
    if (i == N - 1) begin : g_last
      // past the last occupied entry after an erase, never read
      assign right_key[i]   = cmd_key;
      assign right_value[i] = cmd_value;
    end else begin : g_notlast
      assign right_key[i]   = cell_key[i+1];
      assign right_value[i] = cell_value[i+1];
    end

    assign hit[i]     = match[i] && (okvt_pkg::count_t'(i) < count);
    assign pos_sel[i] = (okvt_pkg::CMP_W'(cmd_pos) == okvt_pkg::CMP_W'(i));

    assign cell_ctrl[i].push  = do_push;
    assign cell_ctrl[i].pull  = do_erase && (okvt_pkg::idx_t'(i) >= hit_idx);
    assign cell_ctrl[i].write = do_write && hit[i];

    okvt_cell u_cell (
      .clk         (clk),
      .ctrl        (cell_ctrl[i]),
      .left_key    (left_key[i]),
      .left_value  (left_value[i]),
      .right_key   (right_key[i]),
      .right_value (right_value[i]),
      .cmd_key     (cmd_key),
      .cmd_value   (cmd_value),
      .key         (cell_key[i]),
      .value       (cell_value[i]),
      .match       (match[i])
    );
  end

  // keys are unique among occupied cells, so the hits are one-hot and can be or-ed
  always_comb begin
    hit_idx   = '0;
    hit_value = '0;
    rd_key    = '0;
    rd_value  = '0;
    for (int i = 0; i < N; i++) begin
      if (hit[i]) begin
        hit_idx   = hit_idx | okvt_pkg::idx_t'(i);
        hit_value = hit_value | cell_value[i];
      end
      if (pos_sel[i]) begin
        rd_key   = rd_key | cell_key[i];
        rd_value = rd_value | cell_value[i];
      end
    end
  end

  assign any_hit  = |hit;
  assign in_range = okvt_pkg::CMP_W'(cmd_pos) < okvt_pkg::CMP_W'(count);
  assign full     = (count == okvt_pkg::count_t'(N));

  always_comb begin
    do_push    = 1'b0;
    do_erase   = 1'b0;
    do_write   = 1'b0;
    r_ok       = 1'b0;
    r_status   = okvt_pkg::ST_OK;
    r_key      = cmd_key;
    r_value    = '0;
    count_next = count;
    case (cmd_op)
      okvt_pkg::OP_INSERT: begin
        if (any_hit) begin
          r_status = okvt_pkg::ST_PRESENT;
          r_value  = hit_value;
        end else if (full) begin
          r_status = okvt_pkg::ST_FULL;
        end else begin
          do_push    = do_work;
          r_ok       = 1'b1;
          r_value    = cmd_value;
          count_next = count + 1'b1;
        end
      end
      okvt_pkg::OP_UPDATE: begin
        if (any_hit) begin
          do_write = do_work;
          r_ok     = 1'b1;
          r_value  = cmd_value;
        end else begin
          r_status = okvt_pkg::ST_ABSENT;
        end
      end
      okvt_pkg::OP_UPSERT: begin
        if (any_hit) begin
          do_write = do_work;
          r_ok     = 1'b1;
          r_value  = cmd_value;
        end else if (full) begin
          r_status = okvt_pkg::ST_FULL;
        end else begin
          do_push    = do_work;
          r_ok       = 1'b1;
          r_value    = cmd_value;
          count_next = count + 1'b1;
        end
      end
      okvt_pkg::OP_ERASE: begin
        if (any_hit) begin
          do_erase   = do_work;
          r_ok       = 1'b1;
          r_value    = hit_value;
          count_next = count - 1'b1;
        end else begin
          r_status = okvt_pkg::ST_ABSENT;
        end
      end
      okvt_pkg::OP_LOOKUP: begin
        if (any_hit) begin
          r_ok    = 1'b1;
          r_value = hit_value;
        end else begin
          r_status = okvt_pkg::ST_ABSENT;
        end
      end
      okvt_pkg::OP_READPOS: begin
        if (in_range) begin
          r_ok    = 1'b1;
          r_key   = rd_key;
          r_value = rd_value;
        end else begin
          r_status = okvt_pkg::ST_RANGE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (do_work) begin
      count <= count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (do_work) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_work) begin
      ok          <= r_ok;
      status      <= r_status;
      found_key   <= 32'(r_key);
      found_value <= 32'(r_value);
      entry_count <= 5'(count_next);
    end
  end

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    do_work |=> (count == $past(count)) || (count == $past(count) + 1'b1)
             || (count == $past(count) - 1'b1))
    else $error("entry count moved by more than one");

  a_unique_hit: assert property (@(posedge clk) disable iff (rst)
    busy |-> $onehot0(hit))
    else $error("key stored in more than one occupied cell");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> (count <= okvt_pkg::count_t'(N)))
    else $error("entry count beyond capacity");

  a_ok_status: assert property (@(posedge clk) disable iff (rst)
    (res_valid && ok) |-> (status == okvt_pkg::ST_OK))
    else $error("successful result with error status");

  a_hold_cmd: assert property (@(posedge clk) disable iff (rst)
    (busy && !res_free) |=> busy && $stable(cmd_op) && $stable(cmd_key))
    else $error("pending command lost while result stalled");

endmodule

// File: bench/testbench.sv
// self-checking testbench for the ordered key-value table
`timescale 1ns / 1ps

module testbench;

  // op codes the block does not define, sent to check that they change nothing
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  localparam int POOL_SIZE = 24;
  localparam int RANDOM_ITEMS = 1700;
  localparam int MAX_PRINTS = 40;

  typedef struct {
    logic                 ok;
    okvt_pkg::status_t    status;
    okvt_pkg::key_t       fkey;
    okvt_pkg::value_t     fval;
    okvt_pkg::count_t     count;
  } table_result_t;

  typedef struct {
    logic [2:0]       op;
    okvt_pkg::key_t   key;
    okvt_pkg::value_t value;
    logic [3:0]       position;
    int               reps;
    bit               typed;
    table_result_t    want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cmd_valid = 1'b0;
  logic        cmd_ready;
  logic [2:0]  op = okvt_pkg::OP_LOOKUP;
  logic [31:0] key = '0;
  logic [31:0] value = '0;
  logic [3:0]  position = '0;
  logic        res_valid;
  logic        res_ready = 1'b0;
  logic        ok;
  logic [2:0]  status;
  logic [31:0] found_key;
  logic [31:0] found_value;
  logic [4:0]  entry_count;

  // mirror of the table contents
  okvt_pkg::key_t   table_keys[okvt_pkg::CAPACITY];
  okvt_pkg::value_t table_values[okvt_pkg::CAPACITY];
  int               table_fill = 0;

  table_result_t  pending_results[$];
  int             error_count = 0;
  int             cycle_count = 0;
  int             items_sent = 0;
  bit             fill_phase = 1'b1;
  okvt_pkg::key_t key_pool[POOL_SIZE];
  stim_row_t      directed_rows[20];

  ordered_key_value_table_top DUT (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .op          (op),
    .key         (key),
    .value       (value),
    .position    (position),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .ok          (ok),
    .status      (status),
    .found_key   (found_key),
    .found_value (found_value),
    .entry_count (entry_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1ms;
    $display("[ordered_key_value_table_top] ERROR");
    $finish;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_PRINTS) $display("%0t mismatch: %s", $time, what);
  endtask

  function automatic int find_key(input okvt_pkg::key_t k);
    for (int n = 0; n < table_fill; n++)
      if (table_keys[n] == k) return n;
    return -1;
  endfunction

  function automatic void push_newest(input okvt_pkg::key_t k, input okvt_pkg::value_t v);
    for (int n = table_fill; n > 0; n--) begin
      table_keys[n] = table_keys[n-1];
      table_values[n] = table_values[n-1];
    end
    table_keys[0] = k;
    table_values[0] = v;
    table_fill++;
  endfunction

  // works out the result of one command and applies it to the mirror
  function automatic table_result_t apply_command(input logic [2:0] c_op,
                                                  input okvt_pkg::key_t k,
                                                  input okvt_pkg::value_t v,
                                                  input logic [3:0] pos);
    table_result_t r;
    int at;
    r = '{ok: 1'b0, status: okvt_pkg::ST_OK, fkey: k, fval: '0, count: '0};
    at = find_key(k);
    case (c_op)
      okvt_pkg::OP_INSERT, okvt_pkg::OP_UPSERT: begin
        if (at >= 0 && c_op == okvt_pkg::OP_INSERT) begin
          r.status = okvt_pkg::ST_PRESENT;
          r.fval = table_values[at];
        end else if (at >= 0) begin
          table_values[at] = v;
          r.ok = 1'b1;
          r.fval = v;
        end else if (table_fill >= okvt_pkg::CAPACITY) begin
          r.status = okvt_pkg::ST_FULL;
        end else begin
          push_newest(k, v);
          r.ok = 1'b1;
          r.fval = v;
        end
      end
      okvt_pkg::OP_UPDATE: begin
        if (at >= 0) begin
          table_values[at] = v;
          r.ok = 1'b1;
          r.fval = v;
        end else r.status = okvt_pkg::ST_ABSENT;
      end
      okvt_pkg::OP_ERASE: begin
        if (at >= 0) begin
          r.fval = table_values[at];
          // close the gap, older pairs move one toward the front
          for (int n = at; n + 1 < table_fill; n++) begin
            table_keys[n] = table_keys[n+1];
            table_values[n] = table_values[n+1];
          end
          table_fill--;
          r.ok = 1'b1;
        end else r.status = okvt_pkg::ST_ABSENT;
      end
      okvt_pkg::OP_LOOKUP: begin
        if (at >= 0) begin
          r.ok = 1'b1;
          r.fval = table_values[at];
        end else r.status = okvt_pkg::ST_ABSENT;
      end
      okvt_pkg::OP_READPOS: begin
        if (int'(pos) < table_fill) begin
          r.ok = 1'b1;
          r.fkey = table_keys[pos];
          r.fval = table_values[pos];
        end else r.status = okvt_pkg::ST_RANGE;
      end
      default: ;
    endcase
    r.count = okvt_pkg::count_t'(table_fill);
    return r;
  endfunction

  function automatic int pick_gap(input int stamp);
    int r;
    if ((stamp % 1000) < 150) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // drives one transaction, holds it until taken and records its expected result
  task automatic send_command(input logic [2:0] c_op, input okvt_pkg::key_t k,
                              input okvt_pkg::value_t v, input logic [3:0] pos,
                              input bit typed, input table_result_t want);
    int gap;
    table_result_t predicted;
    gap = pick_gap(items_sent);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    op <= c_op;
    key <= k;
    value <= v;
    position <= pos;
    do @(posedge clk); while (!cmd_ready);
    predicted = apply_command(c_op, k, v, pos);
    pending_results.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  function automatic okvt_pkg::key_t pick_key(input logic [2:0] c_op);
    int r;
    r = $urandom_range(0, 99);
    if ((c_op == okvt_pkg::OP_UPDATE || c_op == okvt_pkg::OP_ERASE ||
         c_op == okvt_pkg::OP_LOOKUP) && table_fill > 0 && r < 45)
      return table_keys[$urandom_range(0, table_fill - 1)];
    if (r < 85) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic logic [2:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return (r == 0) ? OP_SPARE_6 : OP_SPARE_7;
    if (fill_phase) begin
      if (r < 32) return okvt_pkg::OP_INSERT;
      if (r < 57) return okvt_pkg::OP_UPSERT;
      if (r < 67) return okvt_pkg::OP_UPDATE;
      if (r < 75) return okvt_pkg::OP_ERASE;
      if (r < 87) return okvt_pkg::OP_LOOKUP;
      return okvt_pkg::OP_READPOS;
    end
    if (r < 12) return okvt_pkg::OP_INSERT;
    if (r < 20) return okvt_pkg::OP_UPSERT;
    if (r < 30) return okvt_pkg::OP_UPDATE;
    if (r < 70) return okvt_pkg::OP_ERASE;
    if (r < 85) return okvt_pkg::OP_LOOKUP;
    return okvt_pkg::OP_READPOS;
  endfunction

  // result side: random back-pressure and the check of each transaction
  initial begin
    int stall_left;
    int r;
    table_result_t exp_res;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && res_valid && res_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result key=%h", found_key));
        end else begin
          exp_res = pending_results.pop_front();
          if (ok !== exp_res.ok)
            report_mismatch($sformatf("ok %b, want %b", ok, exp_res.ok));
          if (status !== exp_res.status)
            report_mismatch($sformatf("status %0d, want %0d", status, exp_res.status));
          if (found_key !== exp_res.fkey)
            report_mismatch($sformatf("found_key %h, want %h", found_key, exp_res.fkey));
          if (found_value !== exp_res.fval)
            report_mismatch($sformatf("found_value %h, want %h", found_value, exp_res.fval));
          if (entry_count !== exp_res.count)
            report_mismatch($sformatf("entry_count %0d, want %0d", entry_count, exp_res.count));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        res_ready <= 1'b0;
      end else if ((cycle_count % 1000) >= 500 && (cycle_count % 1000) < 650) begin
        res_ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          res_ready <= 1'b1;
        end else begin
          stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(6, 25);
          res_ready <= 1'b0;
        end
      end
    end
  end

  initial begin
    stim_row_t     row;
    table_result_t none;
    logic [2:0]    rnd_op;
    none = '{ok: 1'b0, status: okvt_pkg::ST_OK, fkey: '0, fval: '0, count: '0};
    directed_rows = '{
      '{okvt_pkg::OP_LOOKUP,  32'h0000_0000, 32'h0,         4'd0,  1, 1'b1,
        '{1'b0, okvt_pkg::ST_ABSENT, 32'h0000_0000, 32'h0, 5'd0}},
      '{okvt_pkg::OP_READPOS, 32'h5A5A_5A5A, 32'h0,         4'd0,  1, 1'b1,
        '{1'b0, okvt_pkg::ST_RANGE, 32'h5A5A_5A5A, 32'h0, 5'd0}},
      '{okvt_pkg::OP_UPDATE,  32'h0000_0001, 32'h7,         4'd0,  1, 1'b1,
        '{1'b0, okvt_pkg::ST_ABSENT, 32'h0000_0001, 32'h0, 5'd0}},
      '{okvt_pkg::OP_ERASE,   32'h0000_0002, 32'h0,         4'd0,  1, 1'b1,
        '{1'b0, okvt_pkg::ST_ABSENT, 32'h0000_0002, 32'h0, 5'd0}},
      '{OP_SPARE_6,           32'hA5A5_A5A5, 32'hFFFF_FFFF, 4'd15, 1, 1'b1,
        '{1'b0, okvt_pkg::ST_OK, 32'hA5A5_A5A5, 32'h0, 5'd0}},
      '{okvt_pkg::OP_INSERT,  32'hFFFF_FFFF, 32'h0,         4'd0,  1, 1'b1,
        '{1'b1, okvt_pkg::ST_OK, 32'hFFFF_FFFF, 32'h0, 5'd1}},
      '{okvt_pkg::OP_INSERT,  32'h0000_0000, 32'hFFFF_FFFF, 4'd0,  1, 1'b1,
        '{1'b1, okvt_pkg::ST_OK, 32'h0000_0000, 32'hFFFF_FFFF, 5'd2}},
      '{okvt_pkg::OP_INSERT,  32'h0000_0000, 32'h1,         4'd0,  1, 1'b1,
        '{1'b0, okvt_pkg::ST_PRESENT, 32'h0000_0000, 32'hFFFF_FFFF, 5'd2}},
      '{okvt_pkg::OP_UPSERT,  32'hFFFF_FFFF, 32'h1234_5678, 4'd0,  1, 1'b0, none},
      '{okvt_pkg::OP_READPOS, 32'h0,         32'h0,         4'd1,  1, 1'b0, none},
      '{okvt_pkg::OP_ERASE,   32'hFFFF_FFFF, 32'h0,         4'd0,  1, 1'b0, none},
      // fill up to capacity
      '{okvt_pkg::OP_INSERT,  32'h0000_0100, 32'h0000_1000, 4'd0, 15, 1'b0, none},
      '{okvt_pkg::OP_INSERT,  32'h0000_0003, 32'h9,         4'd0,  1, 1'b1,
        '{1'b0, okvt_pkg::ST_FULL, 32'h0000_0003, 32'h0, 5'd16}},
      '{okvt_pkg::OP_UPSERT,  32'h0000_0004, 32'h9,         4'd0,  1, 1'b1,
        '{1'b0, okvt_pkg::ST_FULL, 32'h0000_0004, 32'h0, 5'd16}},
      '{okvt_pkg::OP_INSERT,  32'h0000_0100, 32'h5,         4'd0,  1, 1'b0, none},
      '{okvt_pkg::OP_READPOS, 32'h0,         32'h0,         4'd15, 1, 1'b0, none},
      '{okvt_pkg::OP_ERASE,   32'h0000_0107, 32'h0,         4'd0,  1, 1'b0, none},
      '{OP_SPARE_7,           32'h0000_0100, 32'h1,         4'd3,  1, 1'b1,
        '{1'b0, okvt_pkg::ST_OK, 32'h0000_0100, 32'h0, 5'd15}},
      '{okvt_pkg::OP_UPDATE,  32'h0000_0000, 32'hDEAD_BEEF, 4'd0,  1, 1'b0, none},
      '{okvt_pkg::OP_LOOKUP,  32'h0000_010E, 32'h0,         4'd0,  1, 1'b0, none}
    };
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      for (int j = 0; j < row.reps; j++)
        send_command(row.op, row.key + okvt_pkg::key_t'(j),
                     row.value + okvt_pkg::value_t'(j), row.position,
                     row.typed, row.want);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // alternate between growing and shrinking the table
      if (n % 100 == 0) fill_phase = ~fill_phase;
      if (n % 250 == 249) key_pool[$urandom_range(2, POOL_SIZE - 1)] = $urandom;
      rnd_op = pick_op();
      send_command(rnd_op, pick_key(rnd_op), $urandom, 4'($urandom_range(0, 15)), 1'b0, none);
    end
    cmd_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("[ordered_key_value_table_top] OK");
    end else begin
      $display("[ordered_key_value_table_top] ERROR");
    end
    $finish;
  end

endmodule

// File: ordered_key_value_table_top.f
hw/rtl/okvt_pkg.sv
hw/rtl/okvt_cell.sv
hw/rtl/ordered_key_value_table_top.sv
bench/testbench.sv
